// File: rtl/core/tvr_pkg.sv
// Shared types, constants and helpers for the tricubic volume resampler.
// Used by tricubic_volume_resampler and tvr_seq under rtl/core; depends on nothing else.
package tvr_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_DIM_X = 64;
  localparam int DEF_MAX_DIM_Y = 64;
  localparam int DEF_MAX_DIM_Z = 64;
  localparam int DEF_FRAC_BITS = 16;

  // Field widths fixed by the interface
  localparam int SAMPLE_W = 16;
  localparam int DIMREG_W = 7;
  localparam int ZSTEP_W  = 24;
  localparam int OUTZ_W   = 10;
  localparam int POS_W    = OUTZ_W + ZSTEP_W;   // out_z * z_step, Q16
  localparam int ZB_W     = POS_W - 16;         // integer slice part
  // signed coordinate width: holds base slice plus offset and any dimension up to 1024
  localparam int CW       = ZB_W + 3;
  // 16 voxels weighted by at most 81, sum of |weights| = 400
  localparam int PLANE_W  = 26;

  localparam logic signed [CW-1:0] C_ONE = CW'(1);

  // Configuration register indexes
  localparam logic [1:0] REG_VOL_WIDTH  = 2'd0;
  localparam logic [1:0] REG_VOL_HEIGHT = 2'd1;
  localparam logic [1:0] REG_VOL_DEPTH  = 2'd2;
  localparam logic [1:0] REG_Z_STEP     = 2'd3;

  localparam logic [DIMREG_W-1:0] RST_DIM    = 7'd64;
  localparam logic [ZSTEP_W-1:0]  RST_ZSTEP  = 24'd65536;

  typedef enum logic [3:0] {
    S_IDLE,
    S_Z0_RD,
    S_Z0_OUT,
    S_POS,
    S_POS_CAP,
    S_U2,
    S_U3,
    S_WGT,
    S_RD,
    S_DRAIN,
    S_MACC,
    S_ACC,
    S_FIN
  } tvr_state_t;

  typedef struct packed {
    logic [DIMREG_W-1:0] vol_width;
    logic [DIMREG_W-1:0] vol_height;
    logic [DIMREG_W-1:0] vol_depth;
    logic [ZSTEP_W-1:0]  z_step;
  } tvr_cfg_t;

  typedef struct packed {
    logic                       done;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       saturated;
  } tvr_res_t;

  // Effective dimension: a zero register counts as 1, capped at the store size
  function automatic logic signed [CW-1:0] dim_eff(input logic [DIMREG_W-1:0] r,
                                                   input logic signed [CW-1:0] maxd);
    logic signed [CW-1:0] ext;
    logic signed [CW-1:0] d;
    ext = $signed({{(CW-DIMREG_W){1'b0}}, r});
    if (r == '0) d = C_ONE;
    else if (ext > maxd) d = maxd;
    else d = ext;
    return d;
  endfunction

  // Clamp-to-edge coordinate
  function automatic logic signed [CW-1:0] clamp_coord(input logic signed [CW-1:0] c,
                                                       input logic signed [CW-1:0] dim);
    logic signed [CW-1:0] r;
    if (c[CW-1]) r = '0;
    else if (c > dim - C_ONE) r = dim - C_ONE;
    else r = c;
    return r;
  endfunction

endpackage

// File: rtl/core/tricubic_volume_resampler.sv
// Tricubic volume resampler (Keys cubic convolution, a = -0.5), top level.
// Depends on tvr_pkg, tvr_vol_mem, tvr_mul and tvr_seq.
//
// Command channel: a word is taken at a clock edge with start high and busy low.
// req_type 0 writes vox_value at (vox_x, vox_y, vox_z) in that same cycle and
// gives no result; busy stays low, so writes can stream one per cycle.
// req_type 1 queries output voxel (out_x, out_y, out_z) and gives one result
// on sample/saturated, marked by done for exactly one cycle.
// Slice 0 query: the clamped voxel at (out_x, out_y, 0) is read and passed on via
// S_Z0_RD and S_Z0_OUT. Other slices: busy through the position product, four
// planes and S_FIN, so a new query is taken only once the last one is done.
// Most time goes to the 64 neighbour reads through the single store read port
// (16 per plane, one per cycle) plus three passes per plane through the one
// shared multiplier (kernel powers and the plane weighting) and position product.
// A new word may be given in the cycle that done is high.
// Configuration: cfg_valid/cfg_ready write channel, always ready; write only
// while idle. Reset clears the sequencer and sets the registers to 64, 64, 64
// and z_step 1.0; the voxel store is undefined until written.
// Results are not held: the receiver must take each one in its done cycle.
module tricubic_volume_resampler #(
  parameter int MAX_DIM_X = tvr_pkg::DEF_MAX_DIM_X,
  parameter int MAX_DIM_Y = tvr_pkg::DEF_MAX_DIM_Y,
  parameter int MAX_DIM_Z = tvr_pkg::DEF_MAX_DIM_Z,
  parameter int FRAC_BITS = tvr_pkg::DEF_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                req_type,
  input  logic [5:0]                          vox_x,
  input  logic [5:0]                          vox_y,
  input  logic [5:0]                          vox_z,
  input  logic signed [tvr_pkg::SAMPLE_W-1:0] vox_value,
  input  logic [5:0]                          out_x,
  input  logic [5:0]                          out_y,
  input  logic [tvr_pkg::OUTZ_W-1:0]          out_z,
  output logic                                done,
  output logic signed [tvr_pkg::SAMPLE_W-1:0] sample,
  output logic                                saturated,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [tvr_pkg::ZSTEP_W-1:0]         cfg_data
);

  localparam int XW = $clog2(MAX_DIM_X);
  localparam int YW = $clog2(MAX_DIM_Y);
  localparam int ZW = $clog2(MAX_DIM_Z);
  localparam int AW = XW + YW + ZW;
  localparam int CW = tvr_pkg::CW;
  localparam int MW = (tvr_pkg::PLANE_W > FRAC_BITS + 4) ? tvr_pkg::PLANE_W : FRAC_BITS + 4;
  localparam int SW = tvr_pkg::SAMPLE_W;

  // configuration registers
  logic [tvr_pkg::DIMREG_W-1:0] vol_width, vol_height, vol_depth;
  logic [tvr_pkg::ZSTEP_W-1:0]  z_step;
  tvr_pkg::tvr_cfg_t            cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vol_width  <= tvr_pkg::RST_DIM;
      vol_height <= tvr_pkg::RST_DIM;
      vol_depth  <= tvr_pkg::RST_DIM;
      z_step     <= tvr_pkg::RST_ZSTEP;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tvr_pkg::REG_VOL_WIDTH:  vol_width  <= cfg_data[tvr_pkg::DIMREG_W-1:0];
        tvr_pkg::REG_VOL_HEIGHT: vol_height <= cfg_data[tvr_pkg::DIMREG_W-1:0];
        tvr_pkg::REG_VOL_DEPTH:  vol_depth  <= cfg_data[tvr_pkg::DIMREG_W-1:0];
        tvr_pkg::REG_Z_STEP:     z_step     <= cfg_data;
        default:                 z_step     <= z_step;
      endcase
    end
  end

  assign cfg.vol_width  = vol_width;
  assign cfg.vol_height = vol_height;
  assign cfg.vol_depth  = vol_depth;
  assign cfg.z_step     = z_step;

  // voxel writes: ignored when a coordinate lies outside the store
  logic          take, wr_en, query;
  logic [CW-1:0] wx, wy, wz;
  logic [AW-1:0] waddr, raddr;
  logic [SW-1:0] rdata;

  assign take  = start && !busy;
  assign query = take && req_type;
  assign wx    = {{(CW-6){1'b0}}, vox_x};
  assign wy    = {{(CW-6){1'b0}}, vox_y};
  assign wz    = {{(CW-6){1'b0}}, vox_z};
  assign wr_en = take && !req_type && (wx < CW'(MAX_DIM_X)) && (wy < CW'(MAX_DIM_Y))
              && (wz < CW'(MAX_DIM_Z));
  assign waddr = {wz[ZW-1:0], wy[YW-1:0], wx[XW-1:0]};

  tvr_vol_mem #(
    .AW(AW),
    .DW(SW)
  ) u_mem (
    .clk  (clk),
    .we   (wr_en),
    .waddr(waddr),
    .wdata(vox_value),
    .raddr(raddr),
    .rdata(rdata)
  );

  logic signed [MW-1:0]   mul_a, mul_b;
  logic signed [2*MW-1:0] mul_p;

  tvr_mul #(
    .W(MW)
  ) u_mul (
    .clk(clk),
    .a  (mul_a),
    .b  (mul_b),
    .p  (mul_p)
  );

  tvr_pkg::tvr_res_t res;

  tvr_seq #(
    .MAX_DIM_X(MAX_DIM_X),
    .MAX_DIM_Y(MAX_DIM_Y),
    .MAX_DIM_Z(MAX_DIM_Z),
    .FRAC_BITS(FRAC_BITS),
    .XW       (XW),
    .YW       (YW),
    .ZW       (ZW),
    .MW       (MW)
  ) u_seq (
    .clk  (clk),
    .rst  (rst),
    .query(query),
    .in_x (out_x),
    .in_y (out_y),
    .in_z (out_z),
    .cfg  (cfg),
    .busy (busy),
    .raddr(raddr),
    .rdata(rdata),
    .mul_a(mul_a),
    .mul_b(mul_b),
    .mul_p(mul_p),
    .res  (res)
  );

  assign done      = res.done;
  assign sample    = res.sample;
  assign saturated = res.saturated;

endmodule

// File: rtl/core/tvr_vol_mem.sv
// Voxel store: one write port, one registered read port.
// Depends on nothing; address width set by the instantiating module.
module tvr_vol_mem #(
  parameter int AW = 18,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // read port, registered: data appears in the cycle after the address
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/tvr_mul.sv
// Shared signed multiplier with a registered product.
// Depends on nothing; operand width set by the instantiating module.
module tvr_mul #(
  parameter int W = 26
) (
  input  logic                  clk,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic signed [2*W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// File: rtl/core/tvr_seq.sv
// Query sequencer: z position, Keys weights, 64 neighbour reads and accumulation.
// Depends on tvr_pkg; drives the shared multiplier and the store read port.
module tvr_seq #(
  parameter int MAX_DIM_X = tvr_pkg::DEF_MAX_DIM_X,
  parameter int MAX_DIM_Y = tvr_pkg::DEF_MAX_DIM_Y,
  parameter int MAX_DIM_Z = tvr_pkg::DEF_MAX_DIM_Z,
  parameter int FRAC_BITS = tvr_pkg::DEF_FRAC_BITS,
  parameter int XW = $clog2(MAX_DIM_X),
  parameter int YW = $clog2(MAX_DIM_Y),
  parameter int ZW = $clog2(MAX_DIM_Z),
  parameter int MW = (tvr_pkg::PLANE_W > FRAC_BITS + 4) ? tvr_pkg::PLANE_W : FRAC_BITS + 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         query,
  input  logic [5:0]                   in_x,
  input  logic [5:0]                   in_y,
  input  logic [tvr_pkg::OUTZ_W-1:0]   in_z,
  input  tvr_pkg::tvr_cfg_t            cfg,
  output logic                         busy,
  output logic [XW+YW+ZW-1:0]          raddr,
  input  logic [tvr_pkg::SAMPLE_W-1:0] rdata,
  output logic signed [MW-1:0]         mul_a,
  output logic signed [MW-1:0]         mul_b,
  input  logic signed [2*MW-1:0]       mul_p,
  output tvr_pkg::tvr_res_t            res
);

  localparam int CW    = tvr_pkg::CW;
  localparam int F     = FRAC_BITS;
  localparam int UW    = F + 2;
  localparam int U2W   = F + 3;
  localparam int U3W   = F + 4;
  localparam int NW    = F + 7;
  localparam int WW    = F + 3;
  localparam int PW    = tvr_pkg::PLANE_W;
  localparam int ACC_W = PW + F + 5;
  localparam int SH    = 8 + F;
  localparam int QW    = ACC_W - SH;
  localparam int SW    = tvr_pkg::SAMPLE_W;

  localparam logic [UW-1:0]          ONE  = UW'(1 << F);
  localparam logic signed [CW-1:0]   MAXX = CW'(MAX_DIM_X);
  localparam logic signed [CW-1:0]   MAXY = CW'(MAX_DIM_Y);
  localparam logic signed [CW-1:0]   MAXZ = CW'(MAX_DIM_Z);
  localparam logic signed [ACC_W-1:0] BIAS = {{(ACC_W-SH){1'b0}}, {SH{1'b1}}};

  tvr_pkg::tvr_state_t state, state_next;

  logic [5:0]                 ox, oy;
  logic [tvr_pkg::OUTZ_W-1:0] oz;
  logic [tvr_pkg::POS_W-1:0]  pos;
  logic [1:0]                 dz;
  logic [3:0]                 cnt;
  logic [U2W-1:0]             u2;
  logic signed [WW-1:0]       wz;
  logic                       rd_vld, rd_ex, rd_ey;
  logic signed [PW-1:0]       plane;
  logic signed [ACC_W-1:0]    acc;

  // fraction rescaled to FRAC_BITS and kernel distance for this plane
  logic [16+F-1:0]       t_sh;
  logic [F-1:0]          t;
  logic [UW-1:0]         t_ext, u;
  logic [U2W-1:0]        u2_p;
  logic [U3W-1:0]        u3_p;
  logic signed [NW-1:0]  ue, u2e, u3e, onee, n, n_adj, n_half, w_full;

  assign t_sh  = {pos[15:0], {F{1'b0}}};
  assign t     = t_sh[16+F-1:16];
  assign t_ext = {2'b00, t};

  always_comb begin
    case (dz)
      2'd0:    u = ONE + t_ext;
      2'd1:    u = t_ext;
      2'd2:    u = ONE - t_ext;
      default: u = (ONE << 1) - t_ext;
    endcase
  end

  assign u2_p = mul_p[2*F+2:F];
  assign u3_p = mul_p[2*F+3:F];

  // Keys kernel, numerator halved toward zero
  assign ue   = $signed({{(NW-UW){1'b0}}, u});
  assign u2e  = $signed({{(NW-U2W){1'b0}}, u2});
  assign u3e  = $signed({{(NW-U3W){1'b0}}, u3_p});
  assign onee = $signed({{(NW-UW){1'b0}}, ONE});

  always_comb begin
    if (u <= ONE) n = (u3e <<< 1) + u3e - ((u2e <<< 2) + u2e);
    else          n = (u2e <<< 2) + u2e - u3e - (ue <<< 3) + (onee <<< 2);
    n_adj  = n + $signed({{(NW-1){1'b0}}, n[NW-1]});
    n_half = n_adj >>> 1;
    if (u[UW-1])       w_full = '0;
    else if (u <= ONE) w_full = n_half + onee;
    else               w_full = n_half;
  end

  // neighbour coordinates, clamped to the volume edge
  logic signed [CW-1:0] dimx, dimy, dimz, offx, offy, cx, cy, cz;
  logic signed [CW-1:0] ix, iy, iz;

  assign dimx = tvr_pkg::dim_eff(cfg.vol_width,  MAXX);
  assign dimy = tvr_pkg::dim_eff(cfg.vol_height, MAXY);
  assign dimz = tvr_pkg::dim_eff(cfg.vol_depth,  MAXZ);

  assign ix    = tvr_pkg::clamp_coord(cx, dimx);
  assign iy    = tvr_pkg::clamp_coord(cy, dimy);
  assign iz    = tvr_pkg::clamp_coord(cz, dimz);
  assign raddr = {iz[ZW-1:0], iy[YW-1:0], ix[XW-1:0]};

  // voxel times x/y weight: corners 1, edges -9, inner 81
  logic signed [SW-1:0] v;
  logic signed [PW-1:0] ve, term;

  assign v  = $signed(rdata);
  assign ve = {{(PW-SW){v[SW-1]}}, v};

  always_comb begin
    if (rd_ex && rd_ey)        term = ve;
    else if (rd_ex || rd_ey)   term = -((ve <<< 3) + ve);
    else                       term = (ve <<< 6) + (ve <<< 4) + ve;
  end

  // final scaling toward zero and saturation
  logic signed [ACC_W-1:0] acc_adj, acc_sh;
  logic signed [QW-1:0]    qs;
  logic signed [SW-1:0]    q_out;
  logic                    q_sat;

  always_comb begin
    acc_adj = acc[ACC_W-1] ? acc + BIAS : acc;
    acc_sh  = acc_adj >>> SH;
    qs      = acc_sh[QW-1:0];
    if (qs > 32767) begin
      q_out = 16'sh7FFF;
      q_sat = 1'b1;
    end else if (qs < -32768) begin
      q_out = -16'sh8000;
      q_sat = 1'b1;
    end else begin
      q_out = qs[SW-1:0];
      q_sat = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tvr_pkg::S_IDLE: begin
        if (query) state_next = (in_z == '0) ? tvr_pkg::S_Z0_RD : tvr_pkg::S_POS;
      end
      tvr_pkg::S_Z0_RD:   state_next = tvr_pkg::S_Z0_OUT;
      tvr_pkg::S_Z0_OUT:  state_next = tvr_pkg::S_IDLE;
      tvr_pkg::S_POS:     state_next = tvr_pkg::S_POS_CAP;
      tvr_pkg::S_POS_CAP: state_next = tvr_pkg::S_U2;
      tvr_pkg::S_U2:      state_next = tvr_pkg::S_U3;
      tvr_pkg::S_U3:      state_next = tvr_pkg::S_WGT;
      tvr_pkg::S_WGT:     state_next = tvr_pkg::S_RD;
      tvr_pkg::S_RD: begin
        if (cnt == 4'd15) state_next = tvr_pkg::S_DRAIN;
      end
      tvr_pkg::S_DRAIN:   state_next = tvr_pkg::S_MACC;
      tvr_pkg::S_MACC:    state_next = tvr_pkg::S_ACC;
      tvr_pkg::S_ACC:     state_next = (dz == 2'd3) ? tvr_pkg::S_FIN : tvr_pkg::S_U2;
      tvr_pkg::S_FIN:     state_next = tvr_pkg::S_IDLE;
      default:            state_next = tvr_pkg::S_IDLE;
    endcase
  end

  // outputs: multiplier operands and read coordinates
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    offx  = '0;
    offy  = '0;
    cz    = '0;
    case (state)
      tvr_pkg::S_POS: begin
        mul_a = $signed({{(MW-tvr_pkg::OUTZ_W){1'b0}}, oz});
        mul_b = $signed({{(MW-tvr_pkg::ZSTEP_W){1'b0}}, cfg.z_step});
      end
      tvr_pkg::S_U2: begin
        mul_a = $signed({{(MW-UW){1'b0}}, u});
        mul_b = $signed({{(MW-UW){1'b0}}, u});
      end
      tvr_pkg::S_U3: begin
        mul_a = $signed({{(MW-U2W){1'b0}}, u2_p});
        mul_b = $signed({{(MW-UW){1'b0}}, u});
      end
      tvr_pkg::S_RD: begin
        offx = $signed({{(CW-2){1'b0}}, cnt[1:0]}) - tvr_pkg::C_ONE;
        offy = $signed({{(CW-2){1'b0}}, cnt[3:2]}) - tvr_pkg::C_ONE;
        cz   = $signed({{(CW-tvr_pkg::ZB_W){1'b0}}, pos[tvr_pkg::POS_W-1:16]})
             + $signed({{(CW-2){1'b0}}, dz}) - tvr_pkg::C_ONE;
      end
      tvr_pkg::S_MACC: begin
        mul_a = {{(MW-PW){plane[PW-1]}}, plane};
        mul_b = {{(MW-WW){wz[WW-1]}}, wz};
      end
      default: begin
        mul_a = '0;
      end
    endcase
    cx = $signed({{(CW-6){1'b0}}, ox}) + offx;
    cy = $signed({{(CW-6){1'b0}}, oy}) + offy;
  end

  assign busy = (state != tvr_pkg::S_IDLE);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tvr_pkg::S_IDLE;
      rd_vld   <= 1'b0;
    end else begin
      state    <= state_next;
      rd_vld   <= (state == tvr_pkg::S_RD);
    end
  end

  // datapath registers and the result word
  always_ff @(posedge clk) begin
    if (rst) res.done <= 1'b0;
    else     res.done <= (state == tvr_pkg::S_Z0_OUT) || (state == tvr_pkg::S_FIN);
    rd_ex <= (cnt[1:0] == 2'd0) || (cnt[1:0] == 2'd3);
    rd_ey <= (cnt[3:2] == 2'd0) || (cnt[3:2] == 2'd3);
    if (rd_vld) plane <= plane + term;
    case (state)
      tvr_pkg::S_IDLE: begin
        if (query) begin
          ox <= in_x;
          oy <= in_y;
          oz <= in_z;
        end
      end
      tvr_pkg::S_Z0_OUT: begin
        res.sample    <= v;
        res.saturated <= 1'b0;
      end
      tvr_pkg::S_POS_CAP: begin
        pos <= mul_p[tvr_pkg::POS_W-1:0];
        dz  <= 2'd0;
        acc <= '0;
      end
      tvr_pkg::S_U3: begin
        u2 <= u2_p;
      end
      tvr_pkg::S_WGT: begin
        wz    <= $signed(w_full[WW-1:0]);
        cnt   <= 4'd0;
        plane <= '0;
      end
      tvr_pkg::S_RD: begin
        cnt <= cnt + 4'd1;
      end
      tvr_pkg::S_ACC: begin
        acc <= acc + mul_p[ACC_W-1:0];
        dz  <= dz + 2'd1;
      end
      tvr_pkg::S_FIN: begin
        res.sample    <= q_out;
        res.saturated <= q_sat;
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

  // a result strobe never repeats back to back
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    res.done |=> !res.done)
    else $error("result strobe held for two cycles");

  // a clipped result sits at one of the range limits
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    (res.done && res.saturated) |-> (res.sample == 16'sh7FFF || res.sample == -16'sh8000))
    else $error("saturated flag without a clipped sample");

  // read data is only accumulated straight after an issued neighbour read
  a_rd_pipe: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> (state == tvr_pkg::S_RD || state == tvr_pkg::S_DRAIN))
    else $error("neighbour data outside the read phase");

  // an accepted query takes the sequencer out of idle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (query && !busy) |=> busy)
    else $error("query accepted but sequencer stayed idle");

endmodule

// File: verif/tvr_tb_pkg.sv
// Request codes shared by the tricubic resampler testbench and its checker.
// Depends on nothing.
package tvr_tb_pkg;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } req_kind_t;

endpackage

// File: verif/tvr_checker.sv
// Scoreboard for the tricubic volume resampler: mirrors the voxel store and registers,
// predicts each query's sample and compares it with the done word.
// Depends on tvr_pkg (field widths, register indexes, reset values) and tvr_tb_pkg.
module tvr_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                busy,
  input  logic                                req_type,
  input  logic [5:0]                          vox_x,
  input  logic [5:0]                          vox_y,
  input  logic [5:0]                          vox_z,
  input  logic signed [tvr_pkg::SAMPLE_W-1:0] vox_value,
  input  logic [5:0]                          out_x,
  input  logic [5:0]                          out_y,
  input  logic [tvr_pkg::OUTZ_W-1:0]          out_z,
  input  logic                                done,
  input  logic signed [tvr_pkg::SAMPLE_W-1:0] sample,
  input  logic                                saturated,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [tvr_pkg::ZSTEP_W-1:0]         cfg_data,
  output int                                  errors,
  output int                                  pending,
  output int                                  checked,
  output int                                  clipped
);
  import tvr_pkg::*;
  import tvr_tb_pkg::*;

  localparam int     FRAC  = DEF_FRAC_BITS;
  localparam longint Q_ONE = longint'(1) << FRAC;
  // x/y taps are Q4 each, z weight Q(FRAC)
  localparam longint SCALE = longint'(1) << (8 + FRAC);

  // mirror of the voxel store, x fastest
  logic signed [SAMPLE_W-1:0] voxel_copy [0:262143];
  logic [DIMREG_W-1:0] width_reg, height_reg, depth_reg;
  logic [ZSTEP_W-1:0]  zstep_reg;
  tvr_res_t            awaited_samples [$];
  tvr_res_t            want;

  initial begin
    errors  = 0;
    pending = 0;
    checked = 0;
    clipped = 0;
  end

  function automatic int eff_dim(input logic [DIMREG_W-1:0] r, input int maxd);
    if (r == '0) return 1;
    if (int'(r) > maxd) return maxd;
    return int'(r);
  endfunction

  function automatic int edge_clamp(input longint c, input int dim);
    if (c < 0) return 0;
    if (c > longint'(dim - 1)) return dim - 1;
    return int'(c);
  endfunction

  function automatic longint voxel_at(input int x, input int y, input int z);
    return longint'(voxel_copy[x + 64 * y + 4096 * z]);
  endfunction

  // Keys kernel (a = -0.5) at distance u >= 0, both in Q(FRAC)
  function automatic longint keys_weight(input longint u);
    longint u2, u3, n;
    if (u >= 2 * Q_ONE) return 0;
    u2 = (u * u) >>> FRAC;
    u3 = (u2 * u) >>> FRAC;
    if (u <= Q_ONE) begin
      n = 3 * u3 - 5 * u2;
      return n / 2 + Q_ONE;
    end
    n = 5 * u2 - u3 - 8 * u + 4 * Q_ONE;
    return n / 2;
  endfunction

  // Expected sample for one output voxel under the current registers and store
  function automatic tvr_res_t resample_voxel(input int ox, input int oy, input int oz);
    tvr_res_t r;
    int       w, h, d, iz, iy, ix;
    longint   pos, zbase, t, u, wz, plane, acc, q;
    int       tap [4] = '{-1, 9, 9, -1};
    w = eff_dim(width_reg, DEF_MAX_DIM_X);
    h = eff_dim(height_reg, DEF_MAX_DIM_Y);
    d = eff_dim(depth_reg, DEF_MAX_DIM_Z);
    r.done      = 1'b1;
    r.saturated = 1'b0;
    // slice zero passes the stored voxel straight through
    if (oz == 0) begin
      r.sample = SAMPLE_W'(voxel_at(edge_clamp(ox, w), edge_clamp(oy, h), 0));
      return r;
    end
    pos   = longint'(oz) * longint'(zstep_reg);
    zbase = pos >>> 16;
    t     = ((pos & 64'hFFFF) << FRAC) >>> 16;
    acc   = 0;
    for (int dz = -1; dz <= 2; dz++) begin
      if (dz == -1) u = Q_ONE + t;
      else if (dz == 0) u = t;
      else if (dz == 1) u = Q_ONE - t;
      else u = 2 * Q_ONE - t;
      wz    = keys_weight(u);
      iz    = edge_clamp(zbase + dz, d);
      plane = 0;
      for (int dy = -1; dy <= 2; dy++) begin
        iy = edge_clamp(longint'(oy + dy), h);
        for (int dx = -1; dx <= 2; dx++) begin
          ix = edge_clamp(longint'(ox + dx), w);
          plane += voxel_at(ix, iy, iz) * tap[dy + 1] * tap[dx + 1];
        end
      end
      acc += plane * wz;
    end
    // truncate toward zero, then clip to 16 bits
    q = acc / SCALE;
    if (q > 32767) begin
      q = 32767;
      r.saturated = 1'b1;
    end
    if (q < -32768) begin
      q = -32768;
      r.saturated = 1'b1;
    end
    r.sample = SAMPLE_W'(q);
    return r;
  endfunction

  // Result words are compared before this edge's command word is taken, since
  // a new query may be accepted in the done cycle of the previous one
  always @(posedge clk) begin
    if (rst) begin
      width_reg  = RST_DIM;
      height_reg = RST_DIM;
      depth_reg  = RST_DIM;
      zstep_reg  = RST_ZSTEP;
      awaited_samples.delete();
    end else begin
      if (done === 1'b1) begin
        if (awaited_samples.size() == 0) begin
          $error("sample word %0d with no query outstanding", sample);
          errors++;
        end else begin
          want = awaited_samples.pop_front();
          checked++;
          if (want.saturated) clipped++;
          if (sample !== want.sample) begin
            $error("sample: expected %0d, got %0d", want.sample, sample);
            errors++;
          end
          if (saturated !== want.saturated) begin
            $error("saturated: expected %0b, got %0b", want.saturated, saturated);
            errors++;
          end
        end
      end

      // register write
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_VOL_WIDTH:  width_reg  = cfg_data[DIMREG_W-1:0];
          REG_VOL_HEIGHT: height_reg = cfg_data[DIMREG_W-1:0];
          REG_VOL_DEPTH:  depth_reg  = cfg_data[DIMREG_W-1:0];
          REG_Z_STEP:     zstep_reg  = cfg_data;
          default: ;
        endcase
      end

      // command word
      if (start && !busy) begin
        if (req_type == REQ_WRITE)
          voxel_copy[int'(vox_x) + 64 * int'(vox_y) + 4096 * int'(vox_z)] = vox_value;
        else
          awaited_samples.push_back(resample_voxel(int'(out_x), int'(out_y), int'(out_z)));
      end
    end
    pending = awaited_samples.size();
  end

endmodule

// File: verif/tricubic_volume_resampler_tb.sv
// Top of the tricubic volume resampler testbench: clock, reset, command and
// register stimulus, verdict. Depends on tvr_pkg, tvr_tb_pkg, tvr_checker and the RTL.
module tricubic_volume_resampler_tb;
  import tvr_pkg::*;
  import tvr_tb_pkg::*;

  localparam int ITEM_TARGET = 1150;

  logic                       clk;
  logic                       rst       = 1'b1;
  logic                       start     = 1'b0;
  logic                       req_type  = 1'b0;
  logic [5:0]                 vox_x     = '0;
  logic [5:0]                 vox_y     = '0;
  logic [5:0]                 vox_z     = '0;
  logic signed [SAMPLE_W-1:0] vox_value = '0;
  logic [5:0]                 out_x     = '0;
  logic [5:0]                 out_y     = '0;
  logic [OUTZ_W-1:0]          out_z     = '0;
  logic                       cfg_valid = 1'b0;
  logic [1:0]                 cfg_index = '0;
  logic [ZSTEP_W-1:0]         cfg_data  = '0;
  logic                       busy, done, saturated, cfg_ready;
  logic signed [SAMPLE_W-1:0] sample;
  int                         errors, pending, checked, clipped;

  int words_sent  = 0;
  int writes_sent = 0;
  int settings    = 0;
  int box_w, box_h, box_d;
  bit no_idle     = 1'b0;
  bit stripe_flip = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  tricubic_volume_resampler u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .vox_x(vox_x), .vox_y(vox_y), .vox_z(vox_z), .vox_value(vox_value),
    .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .done(done), .sample(sample), .saturated(saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  tvr_checker u_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .vox_x(vox_x), .vox_y(vox_y), .vox_z(vox_z), .vox_value(vox_value),
    .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .done(done), .sample(sample), .saturated(saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .checked(checked), .clipped(clipped)
  );

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 16'sh7FFF;
    if (r == 1) return 16'sh8000;
    return SAMPLE_W'($urandom());
  endfunction

  function automatic logic [OUTZ_W-1:0] pick_out_z();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r < 6) return OUTZ_W'($urandom_range(1, 8));
    if (r < 9) return OUTZ_W'($urandom());
    return {OUTZ_W{1'b1}};
  endfunction

  function automatic logic [ZSTEP_W-1:0] pick_z_step();
    case ($urandom_range(0, 7))
      0:       return 24'd1;
      1:       return RST_ZSTEP;
      2:       return {ZSTEP_W{1'b1}};
      3:       return ZSTEP_W'($urandom_range(1, 65535));
      4, 5:    return ZSTEP_W'($urandom_range(65537, 4 * 65536));
      6:       return ZSTEP_W'($urandom());
      default: return ZSTEP_W'(65536 * $urandom_range(2, 5));
    endcase
  endfunction

  function automatic int box_dim(input int r, input int maxd);
    if (r == 0) return 1;
    if (r > maxd) return maxd;
    return r;
  endfunction

  // 4x4 taps at odd x, y all agree in sign with the weights, or all oppose, so sums clip
  function automatic logic signed [SAMPLE_W-1:0] stripe_value(input int x, input int y);
    bit a, b;
    a = ((x + 1) & 2) != 0;
    b = ((y + 1) & 2) != 0;
    return ((a == b) ^ stripe_flip) ? 16'sh7FFF : 16'sh8000;
  endfunction

  // one command word; start stays high across back-to-back words
  task automatic send_word(input req_kind_t kind, input logic [5:0] vx, input logic [5:0] vy,
                           input logic [5:0] vz, input logic signed [SAMPLE_W-1:0] vv,
                           input logic [5:0] ox, input logic [5:0] oy,
                           input logic [OUTZ_W-1:0] oz);
    int gap;
    start     <= 1'b1;
    req_type  <= kind;
    vox_x     <= vx;
    vox_y     <= vy;
    vox_z     <= vz;
    vox_value <= vv;
    out_x     <= ox;
    out_y     <= oy;
    out_z     <= oz;
    do @(posedge clk); while (busy);
    words_sent++;
    if (kind == REQ_WRITE) writes_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_voxel(input int x, input int y, input int z,
                             input logic signed [SAMPLE_W-1:0] v);
    send_word(REQ_WRITE, 6'(x), 6'(y), 6'(z), v,
              6'($urandom()), 6'($urandom()), OUTZ_W'($urandom()));
  endtask

  task automatic query(input int ox, input int oy, input int oz);
    send_word(REQ_QUERY, 6'($urandom()), 6'($urandom()), 6'($urandom()),
              SAMPLE_W'($urandom()), 6'(ox), 6'(oy), OUTZ_W'(oz));
  endtask

  // hold the sender until every outstanding sample has come back
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [ZSTEP_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // new volume setting, only once the block is idle
  task automatic set_volume(input int wr, input int hr, input int dr,
                            input logic [ZSTEP_W-1:0] zs);
    drain();
    repeat (4) @(posedge clk);
    cfg_write(REG_VOL_WIDTH, ZSTEP_W'(wr));
    cfg_write(REG_VOL_HEIGHT, ZSTEP_W'(hr));
    cfg_write(REG_VOL_DEPTH, ZSTEP_W'(dr));
    cfg_write(REG_Z_STEP, zs);
    box_w = box_dim(wr, DEF_MAX_DIM_X);
    box_h = box_dim(hr, DEF_MAX_DIM_Y);
    box_d = box_dim(dr, DEF_MAX_DIM_Z);
    settings++;
  endtask

  // write every voxel a query can reach, so no read hits an unwritten entry
  task automatic fill_box(input bit stripes);
    for (int z = 0; z < box_d; z++)
      for (int y = 0; y < box_h; y++)
        for (int x = 0; x < box_w; x++)
          write_voxel(x, y, z, stripes ? stripe_value(x, y) : pick_value());
  endtask

  task automatic mixed_traffic(input int n);
    repeat (n) begin
      if ($urandom_range(0, 39) == 0) drain();
      if ($urandom_range(0, 1) == 1) begin
        if ($urandom_range(0, 9) < 7)
          query($urandom_range(0, box_w + 1), $urandom_range(0, box_h + 1), pick_out_z());
        else
          query($urandom_range(0, 63), $urandom_range(0, 63), pick_out_z());
      end else if ($urandom_range(0, 1) == 1) begin
        write_voxel($urandom_range(0, box_w - 1), $urandom_range(0, box_h - 1),
                    $urandom_range(0, box_d - 1), pick_value());
      end else begin
        write_voxel($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63),
                    pick_value());
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: 4x4x4 striped volume, half-slice z step
    set_volume(4, 4, 4, 24'd32768);
    fill_box(1'b1);
    write_voxel(63, 63, 63, 16'sh7FFF);
    write_voxel(0, 0, 63, 16'sh8000);
    query(0, 0, 0);
    write_voxel(0, 0, 0, 16'sh8000);
    query(0, 0, 0);
    query(63, 63, 0);
    query(1, 1, 2);
    query(3, 1, 2);
    query(1, 1, 1);
    query(2, 2, 3);
    query(63, 63, 1023);
    query(0, 63, 1);
    write_voxel(1, 1, 1, 16'sd0);
    write_voxel(2, 2, 1, -16'sd1);
    query(1, 1, 2);
    query(1, 2, 3);
    query(5, 0, 1023);

    // zero registers: a single voxel, every slice sampled at z = 0
    set_volume(0, 0, 0, 24'd0);
    fill_box(1'b0);
    mixed_traffic(30);

    // dimension extremes, one at a time
    set_volume(127, 1, 2, {ZSTEP_W{1'b1}});
    fill_box(1'b0);
    mixed_traffic(60);
    set_volume(1, 64, 1, pick_z_step());
    fill_box(1'b0);
    mixed_traffic(60);
    set_volume(1, 1, 127, ZSTEP_W'($urandom_range(1, 65535)));
    fill_box(1'b0);
    mixed_traffic(60);

    // random small volumes until the word budget is spent
    while (words_sent < ITEM_TARGET) begin
      no_idle     = $urandom_range(0, 3) == 0;
      stripe_flip = $urandom_range(0, 1);
      set_volume($urandom_range(1, 5), $urandom_range(1, 5), $urandom_range(1, 5),
                 pick_z_step());
      fill_box($urandom_range(0, 2) == 0);
      mixed_traffic(100);
    end

    drain();
    repeat (120) @(posedge clk);
    @(negedge clk);
    $display("covered %0d command words (%0d voxel writes) over %0d volume settings",
             words_sent, writes_sent, settings);
    $display("compared %0d samples, %0d of them clipped", checked, clipped);
    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/tvr_pkg.sv
rtl/core/tvr_vol_mem.sv
rtl/core/tvr_mul.sv
rtl/core/tvr_seq.sv
rtl/core/tricubic_volume_resampler.sv
verif/tvr_tb_pkg.sv
verif/tvr_checker.sv
verif/tricubic_volume_resampler_tb.sv
